// ===== sv/word_first_occurrence_labeler_assert.svh =====
// ---------------------------------------------------------------------------
// word_first_occurrence_labeler_assert.svh
// Assertion macros shared by the labeler modules. Each macro expects a
// clock named clk and an active-low asynchronous reset named arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef WORD_FIRST_OCCURRENCE_LABELER_ASSERT_SVH
`define WORD_FIRST_OCCURRENCE_LABELER_ASSERT_SVH

// Same-cycle implication
`define WFOL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define WFOL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/wfol_pkg.sv =====
// ---------------------------------------------------------------------------
// wfol_pkg
// Shared widths, defaults, register indexes and controller/datapath structs
// of the word first-occurrence labeler.
// ---------------------------------------------------------------------------
package wfol_pkg;

	// Field widths of the channels
	localparam int SYM_W      = 16;
	localparam int LABEL_W    = 8;
	localparam int LEN_W      = 3;
	localparam int ALPHA_W    = 17;
	localparam int POS_W      = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;

	// Parameter defaults
	localparam int DEF_TABLE_DEPTH  = 256;
	localparam int DEF_MAX_WORD_LEN = 4;
	localparam int DEF_SYMBOL_BITS  = 16;

	// Register reset values
	localparam logic [LEN_W-1:0]   WORD_LEN_RST = 3'd4;
	localparam logic [ALPHA_W-1:0] ALPHA_RST    = 17'h10000;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WORD_LENGTH   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic take;          // accept the offered symbol
		logic search_start;  // restart the table search
		logic search_run;    // advance the table search
		logic finish;        // close the word and load the result
	} wfol_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic word_done;     // offered symbol completes the word
		logic bad_now;       // word holds an out-of-alphabet symbol
		logic search_done;   // search hit or ran past the last entry
		logic out_free;      // result register can take a new result
	} wfol_stat_t;

endpackage

// ===== sv/wfol_if.sv =====
// ---------------------------------------------------------------------------
// wfol_if
// Valid/ready channels of the labeler: symbol input and label result.
// ---------------------------------------------------------------------------
interface wfol_sym_if;
	import wfol_pkg::*;

	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last_in_batch;

	modport source (output valid, symbol, last_in_batch, input ready);
	modport sink   (input valid, symbol, last_in_batch, output ready);
endinterface

interface wfol_res_if;
	import wfol_pkg::*;

	logic               valid;
	logic               ready;
	logic [LABEL_W-1:0] word_label;
	logic               table_full;
	logic               bad_symbol;

	modport source (output valid, word_label, table_full, bad_symbol, input ready);
	modport sink   (input valid, word_label, table_full, bad_symbol, output ready);
endinterface

// ===== sv/wfol_ctrl.sv =====
// ---------------------------------------------------------------------------
// wfol_ctrl
// Controller: takes symbols, runs the table search for each completed word that
// holds no bad symbol and hands the result over once the result register is free.
// ---------------------------------------------------------------------------
module wfol_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sym_valid,
	output logic                sym_ready,
	input  wfol_pkg::wfol_stat_t stat,
	output wfol_pkg::wfol_cmd_t  cmd
);
	import wfol_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_FINISH = 3'b100
	} wfol_state_t;

	wfol_state_t state_q;
	wfol_state_t state_d;

	// Next state and commands
	always_comb begin
		state_d          = state_q;
		cmd              = '0;
		sym_ready        = 1'b0;
		cmd.search_run   = (state_q == ST_SEARCH);
		unique case (state_q)
			ST_IDLE: begin
				sym_ready = 1'b1;
				cmd.take  = sym_valid;
				if (sym_valid && stat.word_done) begin
					if (stat.bad_now) begin
						state_d = ST_FINISH;
					end else begin
						cmd.search_start = 1'b1;
						state_d          = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				if (stat.search_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`include "word_first_occurrence_labeler_assert.svh"

	`WFOL_ASSERT_NXT(a_hold_after_word, cmd.take && stat.word_done, !sym_ready, "input open while a word is in flight")
	`WFOL_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(state_q), "state register not one-hot")
	`WFOL_ASSERT_IMP(a_ready_idle_only, sym_ready, state_q == ST_IDLE, "input ready outside idle")
endmodule

// ===== sv/wfol_dpath.sv =====
// ---------------------------------------------------------------------------
// wfol_dpath
// Datapath: configuration registers, word buffer, stored-word memory with a
// pipelined equality search, label counter and result register.
// ---------------------------------------------------------------------------
module wfol_dpath #(
	parameter int TABLE_DEPTH  = wfol_pkg::DEF_TABLE_DEPTH,
	parameter int MAX_WORD_LEN = wfol_pkg::DEF_MAX_WORD_LEN,
	parameter int SYMBOL_BITS  = wfol_pkg::DEF_SYMBOL_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [wfol_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [wfol_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic [wfol_pkg::SYM_W-1:0]        sym_symbol,
	input  logic                              sym_last,
	input  logic                              res_ready,
	output logic                              res_valid,
	output logic [wfol_pkg::LABEL_W-1:0]      res_label,
	output logic                              res_full,
	output logic                              res_bad,
	input  wfol_pkg::wfol_cmd_t               cmd,
	output wfol_pkg::wfol_stat_t              stat
);
	import wfol_pkg::*;

	localparam int WORD_W = MAX_WORD_LEN * SYMBOL_BITS;
	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

	// Configuration
	logic [LEN_W-1:0]   word_len_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [LEN_W-1:0]   len_eff;

	// Word assembly
	logic [WORD_W-1:0]  buf_q;
	logic [WORD_W-1:0]  buf_d;
	logic [POS_W-1:0]   pos_q;
	logic               bad_q;
	logic               last_q;
	logic               sym_bad;

	// Table and search
	logic [WORD_W-1:0]  mem [TABLE_DEPTH];
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic [CNT_W-1:0]   idx_s1;
	logic [WORD_W-1:0]  rd_data_s1;
	logic               valid_s1;
	logic               hit_q;
	logic [CNT_W-1:0]   hit_idx_q;
	logic               issue;
	logic               store;
	logic               has_room;
	logic [CNT_W-1:0]   label_d;
	logic [CNT_W+LABEL_W-1:0] label_ext;

	// Result register
	logic               out_valid_q;
	logic [LABEL_W-1:0] out_label_q;
	logic               out_full_q;
	logic               out_bad_q;

	// Clamp the word length
	always_comb begin
		len_eff = word_len_q;
		if (word_len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (word_len_q > LEN_W'(MAX_WORD_LEN)) begin
			len_eff = LEN_W'(MAX_WORD_LEN);
		end
	end

	assign sym_bad = ({1'b0, sym_symbol} >= alpha_q);

	// Merge the offered symbol into its lane
	always_comb begin
		buf_d = buf_q;
		for (int k = 0; k < MAX_WORD_LEN; k++) begin
			if (pos_q == POS_W'(k)) begin
				buf_d[k*SYMBOL_BITS +: SYMBOL_BITS] =
					buf_q[k*SYMBOL_BITS +: SYMBOL_BITS] | sym_symbol[SYMBOL_BITS-1:0];
			end
		end
	end

	// Search and result decode
	assign has_room = (count_q < CNT_W'(TABLE_DEPTH));
	assign issue    = cmd.search_run && (rd_idx_q < count_q) && !hit_q;
	assign store    = cmd.finish && !bad_q && !hit_q && has_room;

	always_comb begin
		label_d = '0;
		if (!bad_q) begin
			if (hit_q) begin
				label_d = hit_idx_q;
			end else if (has_room) begin
				label_d = count_q;
			end
		end
	end

	assign label_ext = {{LABEL_W{1'b0}}, label_d};

	// Status
	assign stat.word_done   = ((LEN_W'(pos_q) + LEN_W'(1)) >= len_eff);
	assign stat.bad_now     = bad_q || sym_bad;
	assign stat.search_done = hit_q || (!valid_s1 && (rd_idx_q == count_q));
	assign stat.out_free    = !out_valid_q || res_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_len_q <= WORD_LEN_RST;
			alpha_q    <= ALPHA_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_WORD_LENGTH:   word_len_q <= cfg_wdata[LEN_W-1:0];
				CFG_ALPHABET_SIZE: alpha_q    <= cfg_wdata[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// Word assembly, label counter and search control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q       <= '0;
			pos_q       <= '0;
			bad_q       <= 1'b0;
			count_q     <= '0;
			rd_idx_q    <= '0;
			valid_s1    <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				buf_q <= buf_d;
				bad_q <= bad_q | sym_bad;
				if (!stat.word_done) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
			if (cmd.search_start) begin
				rd_idx_q <= '0;
				valid_s1 <= 1'b0;
				hit_q    <= 1'b0;
			end else if (cmd.search_run) begin
				valid_s1 <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
				if (valid_s1 && (rd_data_s1 == buf_q)) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				buf_q       <= '0;
				pos_q       <= '0;
				bad_q       <= 1'b0;
				hit_q       <= 1'b0;
				valid_s1    <= 1'b0;
				out_valid_q <= 1'b1;
				if (last_q) begin
					count_q <= '0;
				end else if (store) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			last_q <= sym_last;
		end
		if (issue) begin
			idx_s1 <= rd_idx_q;
		end
		if (cmd.search_run && valid_s1 && !hit_q && (rd_data_s1 == buf_q)) begin
			hit_idx_q <= idx_s1;
		end
		if (cmd.finish) begin
			out_label_q <= label_ext[LABEL_W-1:0];
			out_full_q  <= !bad_q && !hit_q && !has_room;
			out_bad_q   <= bad_q;
		end
	end

	// Stored-word memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (store) begin
			mem[count_q[ADDR_W-1:0]] <= buf_q;
		end
		rd_data_s1 <= mem[rd_idx_q[ADDR_W-1:0]];
	end

	assign res_valid = out_valid_q;
	assign res_label = out_label_q;
	assign res_full  = out_full_q;
	assign res_bad   = out_bad_q;

	`include "word_first_occurrence_labeler_assert.svh"

	`WFOL_ASSERT_IMP(a_hit_in_range, hit_q, hit_idx_q < count_q, "hit index beyond the filled table")
	`WFOL_ASSERT_NXT(a_store_counts, store && !last_q, count_q == $past(count_q) + CNT_W'(1), "new word stored without advancing the label")
	`WFOL_ASSERT_IMP(a_bad_clean, res_valid && res_bad, (res_label == '0) && !res_full, "flagged word carries a label or full flag")
endmodule

// ===== sv/word_first_occurrence_labeler.sv =====
// ---------------------------------------------------------------------------
// word_first_occurrence_labeler
// Groups symbols into words and labels each word in order of first
// appearance, searching a table of stored words by equality.
// ---------------------------------------------------------------------------
//  Channel  Dir  Handshake    Carries
//  sym      in   valid/ready  symbol, last_in_batch
//  res      out  valid/ready  word_label, table_full, bad_symbol
//  cfg      in   cfg_we       cfg_idx, cfg_wdata (word_length, alphabet_size)
//
//  A symbol that does not complete a word is taken while the controller is idle.
//  A completing symbol starts a search over the stored words of the batch, read
//  one entry a cycle; a flagged word skips the search.
//  Reset is asynchronous; the table needs no clearing pass, the label count
//  bounds every read. A result waits in the output register while the next
//  symbols are taken; only a second finished word stalls on res.ready.
// ---------------------------------------------------------------------------
module word_first_occurrence_labeler #(
	parameter int TABLE_DEPTH  = wfol_pkg::DEF_TABLE_DEPTH,
	parameter int MAX_WORD_LEN = wfol_pkg::DEF_MAX_WORD_LEN,
	parameter int SYMBOL_BITS  = wfol_pkg::DEF_SYMBOL_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wfol_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [wfol_pkg::CFG_DATA_W-1:0] cfg_wdata,
	wfol_sym_if.sink                        sym,
	wfol_res_if.source                      res
);
	import wfol_pkg::*;

	wfol_cmd_t  cmd;
	wfol_stat_t stat;

	// Sequencing
	wfol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym.valid),
		.sym_ready (sym.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage and search
	wfol_dpath #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.MAX_WORD_LEN (MAX_WORD_LEN),
		.SYMBOL_BITS  (SYMBOL_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.sym_symbol (sym.symbol),
		.sym_last   (sym.last_in_batch),
		.res_ready  (res.ready),
		.res_valid  (res.valid),
		.res_label  (res.word_label),
		.res_full   (res.table_full),
		.res_bad    (res.bad_symbol),
		.cmd        (cmd),
		.stat       (stat)
	);
endmodule
